### rtl/bbmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap miss range finder: shared definitions
// Field widths, request and register codes, and the controller state type.
// ----------------------------------------------------------------------------
package bbmr_pkg;

    localparam int IDX_W      = 12;  // block index and range start
    localparam int POS_W      = 13;  // positions that may reach the block count
    localparam int SPAN_W     = 7;
    localparam int GAP_W      = 6;
    localparam int CFG_W      = 13;
    localparam int REG_W      = 1;
    localparam int REQ_W      = 2;
    localparam int RESULT_CAP = 32;
    localparam int CNT_W      = $clog2(RESULT_CAP);

    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

    localparam logic [REG_W-1:0] REG_MAX_GAP     = 1'b0;
    localparam logic [REG_W-1:0] REG_BLOCK_COUNT = 1'b1;

    localparam logic [GAP_W-1:0] MAX_GAP_RESET     = 6'd4;
    localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QWALK,
        ST_QEND,
        ST_FWALK
    } state_t;

endpackage
`default_nettype wire

### rtl/block_bitmap_miss_range_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap miss range finder
// Presence bitmap of cached blocks with missing-run queries, marking and a
// persistent first-free scan.
// ----------------------------------------------------------------------------
// The presence bitmap lives in a one-bit-wide RAM that is walked one block per
// cycle through its single read port, except while a result waits for the
// output register that the sink still holds. After reset the block runs a
// clearing pass over every block with s_ready low; configuration writes are
// taken during it. A mark is written in its request beat. A range query
// takes the request beat, one bitmap read per covered block, then finishes
// the walk and loads the final result; a find-free request moves the scan
// pointer past present blocks until one is missing or the block count is hit.
// Up to 32 runs are reported per query; later runs are dropped.
module block_bitmap_miss_range_finder #(
    parameter int NUM_BLOCKS = 4096,
    parameter int MAX_SPAN   = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_we,
    input  wire logic [bbmr_pkg::REG_W-1:0]  cfg_index,
    input  wire logic [bbmr_pkg::CFG_W-1:0]  cfg_wdata,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [bbmr_pkg::REQ_W-1:0]  s_req_type,
    input  wire logic [bbmr_pkg::IDX_W-1:0]  s_block_index,
    input  wire logic [bbmr_pkg::SPAN_W-1:0] s_span_blocks,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [bbmr_pkg::IDX_W-1:0]       m_range_start,
    output logic [bbmr_pkg::POS_W-1:0]       m_range_end,
    output logic                             m_range_valid,
    output logic                             m_all_present,
    output logic                             m_last
);
    import bbmr_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);

    state_t state_reg, state_next;

    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [GAP_W-1:0] cfg_gap_reg, cfg_gap_next;
    logic [CFG_W-1:0] cfg_count_reg, cfg_count_next;
    logic [POS_W-1:0] free_ptr_reg, free_ptr_next;
    logic [POS_W-1:0] issue_pos_reg, issue_pos_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic             eval_valid_reg, eval_valid_next;
    logic [POS_W-1:0] eval_pos_reg, eval_pos_next;
    logic             in_run_reg, in_run_next;
    logic             have_run_reg, have_run_next;
    logic [IDX_W-1:0] run_start_reg, run_start_next;
    logic [IDX_W-1:0] run_last_reg, run_last_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic [CNT_W-1:0] result_count_reg, result_count_next;

    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_start_reg, m_start_next;
    logic [POS_W-1:0] m_end_reg, m_end_next;
    logic             m_rvalid_reg, m_rvalid_next;
    logic             m_full_reg, m_full_next;
    logic             m_last_reg, m_last_next;

    logic             ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0]    ram_waddr, ram_raddr;

    logic [POS_W-1:0] live_cnt, span_clip, q_end_full, q_end;
    logic [POS_W-1:0] run_end;
    logic             out_free, bit_missing;
    logic             q_start, q_emit_prev, q_close, q_cap, q_done;
    logic             f_found, f_full, need_out, stall;
    logic             emit, issue;

    bbmr_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A block count above the bitmap size acts as the bitmap size.
    assign live_cnt = (32'(cfg_count_reg) > 32'(NUM_BLOCKS)) ? POS_W'(NUM_BLOCKS)
                                                              : cfg_count_reg;
    assign span_clip = (32'(s_span_blocks) > 32'(MAX_SPAN)) ? POS_W'(MAX_SPAN)
                                                             : POS_W'(s_span_blocks);
    assign q_end_full = {1'b0, s_block_index} + span_clip;
    assign q_end      = (q_end_full > live_cnt) ? live_cnt : q_end_full;
    assign run_end    = {1'b0, run_last_reg} + 1'b1;

    assign out_free    = !m_valid_reg || m_ready;
    assign bit_missing = !ram_rdata;

    assign q_start     = eval_valid_reg && !in_run_reg && bit_missing;
    assign q_emit_prev = q_start && have_run_reg;
    assign q_close     = eval_valid_reg && in_run_reg && !bit_missing &&
                         (gap_reg >= cfg_gap_reg);
    assign q_cap       = q_close && (result_count_reg == CNT_W'(RESULT_CAP - 1));
    assign q_done      = !eval_valid_reg && (issue_pos_reg >= end_reg);

    assign f_found = eval_valid_reg && bit_missing;
    assign f_full  = !eval_valid_reg && (issue_pos_reg >= live_cnt);

    always_comb begin
        need_out = 1'b0;
        unique case (state_reg)
            ST_QWALK: need_out = q_emit_prev || q_cap;
            ST_FWALK: need_out = f_found || f_full;
            default:  need_out = 1'b0;
        endcase
    end

    assign stall = need_out && !out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(NUM_BLOCKS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_req_type == REQ_QUERY) begin
                    state_next = ST_QWALK;
                end else if (s_valid && s_req_type == REQ_FREE) begin
                    state_next = ST_FWALK;
                end
            end
            ST_QWALK: begin
                if (q_cap && out_free) begin
                    state_next = ST_IDLE;
                end else if (q_done) begin
                    state_next = ST_QEND;
                end
            end
            ST_QEND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FWALK: begin
                if ((f_found || f_full) && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory access and result register.
    always_comb begin
        clr_addr_next     = clr_addr_reg;
        cfg_gap_next      = cfg_gap_reg;
        cfg_count_next    = cfg_count_reg;
        free_ptr_next     = free_ptr_reg;
        issue_pos_next    = issue_pos_reg;
        end_next          = end_reg;
        eval_valid_next   = eval_valid_reg;
        eval_pos_next     = eval_pos_reg;
        in_run_next       = in_run_reg;
        have_run_next     = have_run_reg;
        run_start_next    = run_start_reg;
        run_last_next     = run_last_reg;
        gap_next          = gap_reg;
        result_count_next = result_count_reg;
        m_valid_next      = m_valid_reg;
        m_start_next      = m_start_reg;
        m_end_next        = m_end_reg;
        m_rvalid_next     = m_rvalid_reg;
        m_full_next       = m_full_reg;
        m_last_next       = m_last_reg;

        ram_we    = 1'b0;
        ram_waddr = AW'(s_block_index);
        ram_wdata = 1'b1;
        ram_re    = 1'b0;
        ram_raddr = AW'(issue_pos_reg);

        emit  = 1'b0;
        issue = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_GAP:     cfg_gap_next   = cfg_wdata[GAP_W-1:0];
                REG_BLOCK_COUNT: cfg_count_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (s_req_type == REQ_QUERY) begin
                        issue_pos_next    = {1'b0, s_block_index};
                        end_next          = q_end;
                        eval_valid_next   = 1'b0;
                        in_run_next       = 1'b0;
                        have_run_next     = 1'b0;
                        result_count_next = '0;
                    end else if (s_req_type == REQ_FREE) begin
                        issue_pos_next  = free_ptr_reg;
                        eval_valid_next = 1'b0;
                    end else if (s_req_type == REQ_MARK) begin
                        ram_we = ({1'b0, s_block_index} < live_cnt);
                    end else begin
                        ram_we = 1'b0;
                    end
                end
            end
            ST_QWALK: begin
                if (!stall) begin
                    if (eval_valid_reg && in_run_reg) begin
                        if (bit_missing) begin
                            run_last_next = eval_pos_reg[IDX_W-1:0];
                            gap_next      = '0;
                        end else if (q_close) begin
                            // The run closes here; the thirty-second run is final.
                            if (q_cap) begin
                                emit = 1'b1;
                            end
                            in_run_next = 1'b0;
                        end else begin
                            gap_next = gap_reg + 1'b1;
                        end
                    end else if (q_start) begin
                        // A closed run waits until another run starts, so that
                        // only the final one is flagged last.
                        if (have_run_reg) begin
                            emit              = 1'b1;
                            result_count_next = result_count_reg + 1'b1;
                        end
                        run_start_next = eval_pos_reg[IDX_W-1:0];
                        run_last_next  = eval_pos_reg[IDX_W-1:0];
                        gap_next       = '0;
                        in_run_next    = 1'b1;
                        have_run_next  = 1'b1;
                    end
                    issue           = !q_cap && (issue_pos_reg < end_reg);
                    eval_valid_next = issue;
                end
            end
            ST_QEND: begin
                emit = out_free;
            end
            ST_FWALK: begin
                if (!stall) begin
                    if (f_found || f_full) begin
                        emit = 1'b1;
                    end else if (eval_valid_reg) begin
                        free_ptr_next = eval_pos_reg + 1'b1;
                    end
                    issue           = !f_found && (issue_pos_reg < live_cnt);
                    eval_valid_next = issue;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (issue) begin
            ram_re         = 1'b1;
            issue_pos_next = issue_pos_reg + 1'b1;
            eval_pos_next  = issue_pos_reg;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            if (state_reg == ST_FWALK) begin
                m_start_next  = f_found ? eval_pos_reg[IDX_W-1:0] : '0;
                m_end_next    = f_found ? eval_pos_reg + 1'b1 : '0;
                m_rvalid_next = f_found;
                m_full_next   = !f_found;
                m_last_next   = 1'b1;
            end else if (state_reg == ST_QEND) begin
                m_start_next  = have_run_reg ? run_start_reg : '0;
                m_end_next    = have_run_reg ? run_end : '0;
                m_rvalid_next = have_run_reg;
                m_full_next   = 1'b0;
                m_last_next   = 1'b1;
            end else begin
                m_start_next  = run_start_reg;
                m_end_next    = run_end;
                m_rvalid_next = 1'b1;
                m_full_next   = 1'b0;
                m_last_next   = q_cap;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            cfg_gap_reg      <= MAX_GAP_RESET;
            cfg_count_reg    <= BLOCK_COUNT_RESET;
            free_ptr_reg     <= '0;
            eval_valid_reg   <= 1'b0;
            in_run_reg       <= 1'b0;
            have_run_reg     <= 1'b0;
            result_count_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            cfg_gap_reg      <= cfg_gap_next;
            cfg_count_reg    <= cfg_count_next;
            free_ptr_reg     <= free_ptr_next;
            eval_valid_reg   <= eval_valid_next;
            in_run_reg       <= in_run_next;
            have_run_reg     <= have_run_next;
            result_count_reg <= result_count_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_pos_reg <= issue_pos_next;
        end_reg       <= end_next;
        eval_pos_reg  <= eval_pos_next;
        run_start_reg <= run_start_next;
        run_last_reg  <= run_last_next;
        gap_reg       <= gap_next;
        m_start_reg   <= m_start_next;
        m_end_reg     <= m_end_next;
        m_rvalid_reg  <= m_rvalid_next;
        m_full_reg    <= m_full_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_range_start = m_start_reg;
    assign m_range_end   = m_end_reg;
    assign m_range_valid = m_rvalid_reg;
    assign m_all_present = m_full_reg;
    assign m_last        = m_last_reg;

    // A result is only loaded when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result loaded over a beat still held by the sink");

    // Blocks are marked present only between requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_wdata) |-> (state_reg == ST_IDLE))
        else $error("bitmap set outside of a mark beat");

    // A query never evaluates a block past its clipped end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QWALK && eval_valid_reg) |-> (eval_pos_reg < end_reg))
        else $error("query walked past its end");

    // The free scan pointer only moves forward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> (free_ptr_reg >= $past(free_ptr_reg)))
        else $error("free scan pointer moved backward");

    // A walk with a read in flight always reads the block after the one evaluated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_re && eval_valid_reg) |-> (issue_pos_reg == eval_pos_reg + 1'b1))
        else $error("bitmap read out of sequence");

endmodule
`default_nettype wire

### rtl/bbmr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module bbmr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### sim/block_bitmap_miss_range_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap miss range finder testbench
// Drives mark, range-query and find-free requests through the valid/ready
// request channel. A scoreboard tracks its own copy of the presence bitmap,
// scan pointer and registers, predicts every result beat and compares each
// beat that leaves the block, field by field. The run sweeps several register
// settings and idling patterns, and fills the block with the sink held off.
// ----------------------------------------------------------------------------
module block_bitmap_miss_range_finder_tb;
    import bbmr_pkg::*;

    localparam int TOTAL_BLOCKS = 4096;
    localparam int SPAN_LIMIT   = 64;
    localparam int QUIET_CYCLES = 16;
    localparam int END_CYCLES   = 100;
    localparam int HOLD_CYCLES  = 1500;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] rstart;
        logic [POS_W-1:0] rend;
        logic             rvalid;
        logic             rfull;
        logic             rlast;
    } range_beat_t;

    class miss_range_tracker;
        bit          cached [TOTAL_BLOCKS];
        int unsigned gap_limit;
        int unsigned file_blocks;
        int unsigned free_ptr;
        bit          saw_full;
        range_beat_t due_ranges [$];
        int          errors;

        function new();
            gap_limit   = 32'(MAX_GAP_RESET);
            file_blocks = 32'(BLOCK_COUNT_RESET);
            free_ptr    = 0;
            saw_full    = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [REG_W-1:0] which, logic [CFG_W-1:0] data);
            if (which == REG_MAX_GAP) begin
                gap_limit = 32'(data[GAP_W-1:0]);
            end else begin
                file_blocks = 32'(data);
            end
        endfunction

        function int unsigned live_blocks();
            return (file_blocks > TOTAL_BLOCKS) ? TOTAL_BLOCKS : file_blocks;
        endfunction

        function int pending();
            return due_ranges.size();
        endfunction

        function void push_beat(int unsigned rs, int unsigned re, bit v, bit a, bit l);
            range_beat_t b;
            b.rstart = IDX_W'(rs);
            b.rend   = POS_W'(re);
            b.rvalid = v;
            b.rfull  = a;
            b.rlast  = l;
            due_ranges = {due_ranges, b};
        endfunction

        function void take_request(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] idx,
                                   logic [SPAN_W-1:0] span_in);
            int unsigned cnt, span, stop, p, rs, lm, gap;
            int unsigned starts [$];
            int unsigned ends [$];
            cnt = live_blocks();
            case (kind)
                REQ_QUERY: begin
                    span = 32'(span_in);
                    if (span > SPAN_LIMIT) span = SPAN_LIMIT;
                    stop = 32'(idx) + span;
                    if (stop > cnt) stop = cnt;
                    p = 32'(idx);
                    while (p < stop) begin
                        while (p < stop && cached[p]) p++;
                        if (p >= stop) break;
                        rs  = p;
                        lm  = p;
                        gap = 0;
                        // A run closes once more present blocks follow in a row
                        // than the gap limit allows.
                        while (p < stop) begin
                            if (!cached[p]) begin
                                lm  = p;
                                gap = 0;
                            end else begin
                                gap++;
                                if (gap > gap_limit) break;
                            end
                            p++;
                        end
                        if (starts.size() < RESULT_CAP) begin
                            starts = {starts, rs};
                            ends   = {ends, lm + 1};
                        end
                        p++;
                    end
                    if (starts.size() == 0) begin
                        push_beat(0, 0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < starts.size(); i++) begin
                            push_beat(starts[i], ends[i], 1'b1, 1'b0, i == starts.size() - 1);
                        end
                    end
                end
                REQ_MARK: begin
                    if (32'(idx) < cnt) cached[idx] = 1'b1;
                end
                REQ_FREE: begin
                    while (free_ptr < cnt && cached[free_ptr]) free_ptr++;
                    if (free_ptr < cnt) begin
                        push_beat(free_ptr, free_ptr + 1, 1'b1, 1'b0, 1'b1);
                    end else begin
                        saw_full = 1'b1;
                        push_beat(0, 0, 1'b0, 1'b1, 1'b1);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic [IDX_W-1:0] rs, logic [POS_W-1:0] re,
                                   logic v, logic a, logic l);
            range_beat_t exp_beat;
            if (due_ranges.size() == 0) begin
                $error("unexpected result beat: range_start %0d range_end %0d", rs, re);
                errors++;
                return;
            end
            exp_beat = due_ranges.pop_front();
            compare_field("range_start", 32'(exp_beat.rstart), 32'(rs));
            compare_field("range_end", 32'(exp_beat.rend), 32'(re));
            compare_field("range_valid", 32'(exp_beat.rvalid), 32'(v));
            compare_field("all_present", 32'(exp_beat.rfull), 32'(a));
            compare_field("last", 32'(exp_beat.rlast), 32'(l));
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [REG_W-1:0]  cfg_index = REG_MAX_GAP;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type    = REQ_QUERY;
    logic [IDX_W-1:0]  s_block_index = '0;
    logic [SPAN_W-1:0] s_span_blocks = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [IDX_W-1:0]  m_range_start;
    logic [POS_W-1:0]  m_range_end;
    logic              m_range_valid;
    logic              m_all_present;
    logic              m_last;

    miss_range_tracker tracker;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int recv_hold      = 0;
    int items_sent     = 0;

    block_bitmap_miss_range_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_block_index (s_block_index),
        .s_span_blocks (s_span_blocks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_start (m_range_start),
        .m_range_end   (m_range_end),
        .m_range_valid (m_range_valid),
        .m_all_present (m_all_present),
        .m_last        (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The sink: random stalls, or a long hold-off counted down here.
    initial begin
        forever begin
            @(negedge aclk);
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result(m_range_start, m_range_end, m_range_valid,
                                 m_all_present, m_last);
        end
    end

    // Called and returns at a falling edge; the beat stays up until accepted.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [SPAN_W-1:0] span);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_block_index <= idx;
        s_span_blocks <= span;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_request(kind, idx, span);
        if (kind != REQ_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic program_reg(input logic [REG_W-1:0] which, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.write_reg(which, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Marks give no result, so quiet cycles follow the last result to let them finish.
    task automatic drain_and_quiet();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int items, input int s_idle, input int r_idle,
                             input logic [CFG_W-1:0] gap_val,
                             input logic [CFG_W-1:0] count_val);
        int unsigned live, base;
        int target;
        drain_and_quiet();
        program_reg(REG_MAX_GAP, gap_val);
        program_reg(REG_BLOCK_COUNT, count_val);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_idle;
        live   = tracker.live_blocks();
        target = items_sent + items;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                send_req(REQ_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 4095)),
                         SPAN_W'($urandom_range(0, 127)));
            end else begin
                // Cluster marks in a window, then query across it.
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(0, 4095);
                    1: base = tracker.free_ptr;
                    default: base = (live > 0) ? $urandom_range(0, live - 1) : 0;
                endcase
                repeat ($urandom_range(0, 10)) begin
                    send_req(REQ_MARK, IDX_W'(base + $urandom_range(0, 63)),
                             SPAN_W'($urandom_range(0, 127)));
                end
                repeat ($urandom_range(1, 3)) begin
                    send_req(REQ_QUERY, IDX_W'(base + $urandom_range(0, 8)),
                             SPAN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                  : $urandom_range(0, 64)));
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_req(REQ_FREE, IDX_W'($urandom_range(0, 4095)),
                             SPAN_W'($urandom_range(0, 127)));
                end
            end
        end
    endtask

    initial begin
        #(2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        tracker = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset register values.
        send_req(REQ_QUERY, 12'd0, 7'd0);
        send_req(REQ_QUERY, 12'd0, 7'd64);
        send_req(REQ_QUERY, 12'd4095, 7'd127);
        send_req(REQ_UNUSED, 12'd4095, 7'd127);
        send_req(REQ_FREE, 12'd0, 7'd0);
        send_req(REQ_MARK, 12'd0, 7'd0);
        send_req(REQ_MARK, 12'd1, 7'd0);
        send_req(REQ_MARK, 12'd3, 7'd0);
        send_req(REQ_MARK, 12'd10, 7'd0);
        send_req(REQ_MARK, 12'd4095, 7'd0);
        send_req(REQ_FREE, 12'd0, 7'd0);
        send_req(REQ_QUERY, 12'd0, 7'd20);
        send_req(REQ_QUERY, 12'd4095, 7'd1);

        // Small file: a mark past the end is dropped and find-free runs out.
        drain_and_quiet();
        program_reg(REG_MAX_GAP, 13'h1FC0);
        program_reg(REG_BLOCK_COUNT, 13'd5);
        send_req(REQ_MARK, 12'd5, 7'd0);
        send_req(REQ_MARK, 12'd2, 7'd0);
        send_req(REQ_MARK, 12'd4, 7'd0);
        send_req(REQ_FREE, 12'd0, 7'd0);
        send_req(REQ_QUERY, 12'd0, 7'd64);

        // No blocks at all.
        drain_and_quiet();
        program_reg(REG_BLOCK_COUNT, 13'd0);
        program_reg(REG_MAX_GAP, 13'd63);
        send_req(REQ_QUERY, 12'd0, 7'd10);
        send_req(REQ_FREE, 12'd0, 7'd0);
        send_req(REQ_MARK, 12'd100, 7'd0);

        // A count above the bitmap size acts as the full bitmap.
        drain_and_quiet();
        program_reg(REG_BLOCK_COUNT, 13'd8191);
        send_req(REQ_QUERY, 12'd90, 7'd20);
        send_req(REQ_QUERY, 12'd0, 7'd64);
        send_req(REQ_FREE, 12'd0, 7'd0);

        run_phase(45, 0, 0, CFG_W'($urandom_range(0, 8191)), 13'd4096);
        run_phase(45, 75, 0, 13'd0, CFG_W'($urandom_range(1, 200)));
        run_phase(45, 0, 75, 13'd63, CFG_W'($urandom_range(4097, 8191)));
        run_phase(45, 10, 10, CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(1, 4096)));

        // Alternate present and missing blocks so each query yields a full set
        // of runs, then hold the sink off while queries keep coming.
        drain_and_quiet();
        program_reg(REG_MAX_GAP, 13'd0);
        program_reg(REG_BLOCK_COUNT, 13'd4096);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < 32; k++) begin
            send_req(REQ_MARK, IDX_W'(1024 + 2 * k + 1), 7'd0);
        end
        recv_hold = HOLD_CYCLES;
        repeat (20) send_req(REQ_QUERY, 12'd1024, 7'd64);
        drain_and_quiet();

        repeat (END_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
